FILE: hdl/rsvg_pkg.sv
package rsvg_pkg;

  localparam int NUM_W = 45;  // widest dividend: slice index above a 32-bit turn fraction
  localparam int SLC_W = 13;
  localparam int STK_W = 7;
  localparam int IDX_W = 6;
  localparam int RAD_W = 32;
  localparam int TEX_W = 17;
  localparam int CRD_W = 33;
  localparam int TRG_W = 17;
  localparam int IN_W  = 24;
  localparam int OUT_W = 168;
  localparam int CFG_IDX_W = 3;

  localparam int DEF_MAX_SLICES = 4096;
  localparam int DEF_MAX_STACKS = 64;

  localparam logic [TRG_W-1:0] SIN_A   = 17'd102944;
  localparam logic [TRG_W-1:0] SIN_B   = 17'd42048;
  localparam logic [TRG_W-1:0] SIN_C   = 17'd4640;
  localparam logic [TRG_W-1:0] Q16_ONE = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INNER  = 3'd0,
    REG_OUTER  = 3'd1,
    REG_SLICES = 3'd2,
    REG_STACKS = 3'd3,
    REG_UPPER  = 3'd4
  } reg_idx_t;

  // one classified request, ready for the dividers
  typedef struct packed {
    logic [NUM_W-1:0] ph_num;
    logic [SLC_W-1:0] slices;
    logic             upper;
    logic [NUM_W-1:0] r0_num;
    logic [NUM_W-1:0] r1_num;
    logic [STK_W-1:0] stacks;
    logic [NUM_W-1:0] t0_num;
    logic [NUM_W-1:0] t1_num;
  } item_t;

endpackage

FILE: hdl/rsvg_div.sv
module rsvg_div import rsvg_pkg::*; #(
  parameter int DEN_W = 8
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];
  logic [NUM_W-1:0] quo_r [NUM_W];

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_p;
    logic [NUM_W-1:0] num_p;
    logic [DEN_W-1:0] den_p;
    logic [NUM_W-1:0] quo_p;
    logic [DEN_W:0]   sh;
    logic             ge;
    logic [DEN_W:0]   diff;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign num_p = num_i;
      assign den_p = den_i;
      assign quo_p = '0;
    end else begin : g_rest
      assign rem_p = rem_r[k-1];
      assign num_p = num_r[k-1];
      assign den_p = den_r[k-1];
      assign quo_p = quo_r[k-1];
    end

    assign sh   = {rem_p, num_p[NUM_W-1]};
    assign ge   = (sh >= {1'b0, den_p});
    assign diff = sh - {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        num_r[k] <= {num_p[NUM_W-2:0], 1'b0};
        den_r[k] <= den_p;
        quo_r[k] <= {quo_p[NUM_W-2:0], ge};
      end
    end
  end

  assign quo_o = quo_r[NUM_W-1];

endmodule

FILE: hdl/rsvg_front.sv
module rsvg_front import rsvg_pkg::*; #(
  parameter int MAX_SLICES = DEF_MAX_SLICES,
  parameter int MAX_STACKS = DEF_MAX_STACKS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [IN_W-1:0]      in_tdata,
  output item_t                item_o
);

  logic [RAD_W-1:0] inner_r, outer_r;
  logic [SLC_W-1:0] slices_r;
  logic [STK_W-1:0] stacks_r;
  logic             upper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r  <= '0;
      outer_r  <= RAD_W'(32'd65536);
      slices_r <= SLC_W'(4);
      stacks_r <= STK_W'(4);
      upper_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_INNER:  inner_r  <= cfg_data;
        REG_OUTER:  outer_r  <= cfg_data;
        REG_SLICES: slices_r <= cfg_data[SLC_W-1:0];
        REG_STACKS: stacks_r <= cfg_data[STK_W-1:0];
        REG_UPPER:  upper_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [SLC_W-1:0] n_c;
  logic [STK_W-1:0] s_c, i_c;
  logic [IDX_W-1:0] i_in;
  logic [SLC_W-1:0] j_in;
  logic [NUM_W-1:0] hs;

  assign i_in = in_tdata[IDX_W-1:0];
  assign j_in = in_tdata[IDX_W +: SLC_W];

  always_comb begin
    if (slices_r == '0) n_c = SLC_W'(1);
    else if (32'(slices_r) > 32'(MAX_SLICES)) n_c = SLC_W'(MAX_SLICES);
    else n_c = slices_r;
    if (stacks_r == '0) s_c = STK_W'(1);
    else if (32'(stacks_r) > 32'(MAX_STACKS)) s_c = STK_W'(MAX_STACKS);
    else s_c = stacks_r;
    if (STK_W'(i_in) > s_c - STK_W'(1)) i_c = s_c - STK_W'(1);
    else i_c = STK_W'(i_in);
  end

  assign hs = NUM_W'(s_c >> 1);

  always_comb begin
    item_o.ph_num = (j_in < n_c) ? ({j_in, 32'b0} + NUM_W'(n_c >> 1)) : '0;
    item_o.slices = n_c;
    item_o.upper  = upper_r;
    item_o.r0_num = NUM_W'(inner_r) * NUM_W'(s_c - i_c)
                  + NUM_W'(outer_r) * NUM_W'(i_c) + hs;
    item_o.r1_num = NUM_W'(inner_r) * NUM_W'(s_c - i_c - STK_W'(1))
                  + NUM_W'(outer_r) * NUM_W'(i_c + STK_W'(1)) + hs;
    item_o.stacks = s_c;
    item_o.t0_num = (NUM_W'(i_c) << 16) + hs;
    item_o.t1_num = (NUM_W'(i_c + STK_W'(1)) << 16) + hs;
  end

endmodule

FILE: hdl/rsvg_queue.sv
module rsvg_queue import rsvg_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_i,
  input  item_t data_i,
  input  logic  pop_i,
  output item_t data_o,
  output logic  full_o,
  output logic  empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full_o  = (cnt_r == CNT_W'(DEPTH));
  assign empty_o = (cnt_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= data_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
      cnt_r <= cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

FILE: hdl/rsvg_back.sv
module rsvg_back import rsvg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  item_t            item_i,
  input  logic             item_valid,
  output logic             pop_o,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  typedef struct packed {
    logic [RAD_W-1:0] r0;
    logic [RAD_W-1:0] r1;
    logic [TEX_W-1:0] t0;
    logic [TEX_W-1:0] t1;
    logic             ns;
    logic             nc;
  } carry_t;

  logic en;
  assign en    = !out_tvalid || out_tready;
  assign pop_o = en && item_valid;

  logic [NUM_W-1:0] ph_q, r0_q, r1_q, t0_q, t1_q;

  rsvg_div #(.DEN_W(SLC_W)) u_div_ph (.clk, .en, .num_i(item_i.ph_num),
    .den_i(item_i.slices), .quo_o(ph_q));
  rsvg_div #(.DEN_W(STK_W)) u_div_r0 (.clk, .en, .num_i(item_i.r0_num),
    .den_i(item_i.stacks), .quo_o(r0_q));
  rsvg_div #(.DEN_W(STK_W)) u_div_r1 (.clk, .en, .num_i(item_i.r1_num),
    .den_i(item_i.stacks), .quo_o(r1_q));
  rsvg_div #(.DEN_W(STK_W)) u_div_t0 (.clk, .en, .num_i(item_i.t0_num),
    .den_i(item_i.stacks), .quo_o(t0_q));
  rsvg_div #(.DEN_W(STK_W)) u_div_t1 (.clk, .en, .num_i(item_i.t1_num),
    .den_i(item_i.stacks), .quo_o(t1_q));

  // valid and direction ride alongside the divider stages
  logic [NUM_W-1:0] dv_r, up_r;
  always_ff @(posedge clk) begin
    if (!rst_n) dv_r <= '0;
    else if (en) dv_r <= {dv_r[NUM_W-2:0], pop_o};
  end
  always_ff @(posedge clk) begin
    if (en) up_r <= {up_r[NUM_W-2:0], item_i.upper};
  end

  // phase to quarter-wave arguments
  logic [31:0]      p, pc;
  logic [TRG_W-1:0] xs_nxt, xc_nxt;
  assign p      = up_r[NUM_W-1] ? (32'd0 - ph_q[31:0]) : ph_q[31:0];
  assign pc     = p + 32'h4000_0000;
  assign xs_nxt = p[30]  ? (Q16_ONE - TRG_W'(p[29:14]))  : TRG_W'(p[29:14]);
  assign xc_nxt = pc[30] ? (Q16_ONE - TRG_W'(pc[29:14])) : TRG_W'(pc[29:14]);

  logic             v1_r, v2_r, v3_r, v4_r, v5_r;
  carry_t           c1_r, c2_r, c3_r, c4_r, c5_r;
  logic [TRG_W-1:0] xs1_r, xc1_r, xs2_r, xc2_r, xs3_r, xc3_r, xs4_r, xc4_r;
  logic [TRG_W-1:0] x2s2_r, x2c2_r, x2s3_r, x2c3_r;
  logic [TRG_W-1:0] ts3_r, tc3_r, us4_r, uc4_r, ms5_r, mc5_r;

  logic [33:0] sq_s, sq_c, pm_s, pm_c;
  logic [31:0] ct_s, ct_c;
  logic [33:0] ut_s, ut_c;
  logic [TRG_W-1:0] ms_nxt, mc_nxt;

  assign sq_s = 34'(xs1_r) * 34'(xs1_r);
  assign sq_c = 34'(xc1_r) * 34'(xc1_r);
  assign ct_s = 32'(SIN_C) * 32'(x2s2_r);
  assign ct_c = 32'(SIN_C) * 32'(x2c2_r);
  assign ut_s = 34'(x2s3_r) * 34'(ts3_r);
  assign ut_c = 34'(x2c3_r) * 34'(tc3_r);
  assign pm_s = 34'(xs4_r) * 34'(us4_r);
  assign pm_c = 34'(xc4_r) * 34'(uc4_r);
  assign ms_nxt = (pm_s[33:16] > 18'(Q16_ONE)) ? Q16_ONE : pm_s[16+:TRG_W];
  assign mc_nxt = (pm_c[33:16] > 18'(Q16_ONE)) ? Q16_ONE : pm_c[16+:TRG_W];

  // scale and sign
  function automatic logic [CRD_W-1:0] scale(input logic [RAD_W-1:0] r,
                                             input logic [TRG_W-1:0] m,
                                             input logic neg);
    logic [48:0]      prod;
    logic [CRD_W-1:0] v;
    prod = 49'(r) * 49'(m) + 49'(32768);
    v    = prod[48:16];
    return (neg && (m != '0)) ? (CRD_W'(0) - v) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      out_tvalid <= 1'b0;
    end else if (en) begin
      v1_r <= dv_r[NUM_W-1];
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      out_tvalid <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r   <= '{r0: r0_q[RAD_W-1:0], r1: r1_q[RAD_W-1:0], t0: t0_q[TEX_W-1:0],
                  t1: t1_q[TEX_W-1:0], ns: p[31], nc: pc[31]};
      xs1_r  <= xs_nxt;
      xc1_r  <= xc_nxt;
      c2_r   <= c1_r;
      xs2_r  <= xs1_r;
      xc2_r  <= xc1_r;
      x2s2_r <= sq_s[16+:TRG_W];
      x2c2_r <= sq_c[16+:TRG_W];
      c3_r   <= c2_r;
      xs3_r  <= xs2_r;
      xc3_r  <= xc2_r;
      x2s3_r <= x2s2_r;
      x2c3_r <= x2c2_r;
      ts3_r  <= SIN_B - TRG_W'(ct_s[31:16]);
      tc3_r  <= SIN_B - TRG_W'(ct_c[31:16]);
      c4_r   <= c3_r;
      xs4_r  <= xs3_r;
      xc4_r  <= xc3_r;
      us4_r  <= SIN_A - ut_s[16+:TRG_W];
      uc4_r  <= SIN_A - ut_c[16+:TRG_W];
      c5_r   <= c4_r;
      ms5_r  <= ms_nxt;
      mc5_r  <= mc_nxt;
      out_tdata <= {2'b00,
                    c5_r.t1,
                    scale(c5_r.r1, ms5_r, c5_r.ns),
                    scale(c5_r.r1, mc5_r, c5_r.nc),
                    c5_r.t0,
                    scale(c5_r.r0, ms5_r, c5_r.ns),
                    scale(c5_r.r0, mc5_r, c5_r.nc)};
    end
  end

endmodule

FILE: hdl/ring_strip_vertex_generator_unit.sv
// Ring strip vertex generator.
// Requests arrive on the in_ stream: each transaction names a stack (radial
// band) and a slice (angular step) of a flat ring; one result transaction
// leaves on the out_ stream with the inner and outer strip vertices (x, y in
// signed Q16.16) and their texture coordinates (unsigned Q1.16).
// Ring geometry is set through the cfg_ write channel (inner/outer radius,
// slice count, stack count, direction); cfg_ready is always high. Write it
// only while no request is in flight.
// Throughput: one transaction per cycle sustained while out_tready stays high. From
// input acceptance to out_tvalid a request passes the front queue, then
// the 45 bit-per-stage division stages (phase, radii, texture), then six
// stages of polynomial sine/cosine and radius scaling.
// A synchronous active-low reset empties the queue and pipeline and loads
// the default geometry (radius 0 to 1.0, four slices, four stacks).
// When the receiver stalls the whole back pipeline holds; the four-entry
// queue absorbs requests until full, then in_tready drops.
module ring_strip_vertex_generator_unit import rsvg_pkg::*; #(
  parameter int MAX_SLICES = DEF_MAX_SLICES,
  parameter int MAX_STACKS = DEF_MAX_STACKS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // stack_index [5:0], slice_index [18:6], zero pad
  input  logic [IN_W-1:0]      in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // inner_x, inner_y, inner_tex, outer_x, outer_y, outer_tex, zero pad
  output logic [OUT_W-1:0]     out_tdata
);

  item_t front_item, head_item;
  logic  q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;

  // classify: clamp counts and stack index, map out-of-range slices to phase zero, and form the dividends
  rsvg_front #(.MAX_SLICES(MAX_SLICES), .MAX_STACKS(MAX_STACKS)) u_front (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data, .in_tdata,
    .item_o(front_item)
  );

  // decouple front from back so each side stalls on its own
  rsvg_queue #(.DEPTH(4)) u_queue (
    .clk, .rst_n,
    .push_i(in_tvalid), .data_i(front_item),
    .pop_i(q_pop), .data_o(head_item),
    .full_o(q_full), .empty_o(q_empty)
  );

  rsvg_back u_back (
    .clk, .rst_n,
    .item_i(head_item), .item_valid(!q_empty), .pop_o(q_pop),
    .out_tvalid, .out_tready, .out_tdata
  );

endmodule
